// ===== rtl/vfqvb_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel face quad vertex builder package
// Shared constants, the corner offset table and the item type handed from
// the seam-select stages to the vertex emitter.
// ----------------------------------------------------------------------------
package vfqvb_pkg;

    localparam int CHUNK_EDGE = 32;

    // Largest legal block coordinate, in the 6-bit width of a vertex coordinate.
    localparam logic [5:0] EDGE_MAX = 6'(CHUNK_EDGE - 1);

    localparam int COORD_W = 5;
    localparam int FACE_W  = 3;
    localparam int TEX_W   = 12;
    localparam int LEVEL_W = 16;

    typedef logic [1:0] corner_t;

    // Offset bits are written as {dx, dy, dz}.
    typedef logic [2:0] offset_t;

    localparam offset_t CORNER_OFFSET [0:7][0:3] = '{
        '{3'b010, 3'b000, 3'b011, 3'b001},  // west
        '{3'b100, 3'b110, 3'b101, 3'b111},  // east
        '{3'b000, 3'b100, 3'b001, 3'b101},  // south
        '{3'b110, 3'b010, 3'b111, 3'b011},  // north
        '{3'b010, 3'b110, 3'b000, 3'b100},  // bottom
        '{3'b001, 3'b101, 3'b011, 3'b111},  // top
        '{3'b000, 3'b000, 3'b000, 3'b000},  // no such face
        '{3'b000, 3'b000, 3'b000, 3'b000}   // no such face
    };

    typedef struct packed {
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] bz;
        logic [FACE_W-1:0]  face;
        logic [TEX_W-1:0]   tex;
        logic [LEVEL_W-1:0] sun;
        logic [LEVEL_W-1:0] occ;
        logic               flip;
    } item_t;

    // Corner emitted at a given slot when the seam is flipped.
    function automatic corner_t flipped_corner(input corner_t slot);
        corner_t c;
        unique case (slot)
            2'd0:    c = 2'd1;
            2'd1:    c = 2'd3;
            2'd2:    c = 2'd0;
            default: c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/vfqvb_vertex_emit.sv =====
// ----------------------------------------------------------------------------
// Vertex emitter
// Holds one face and sends its four vertices, one per beat, through a
// registered output stage.
// ----------------------------------------------------------------------------
module vfqvb_vertex_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  vfqvb_pkg::item_t     item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          vertex_word,
    output logic [23:0]          light_word,
    output logic [1:0]           slot,
    output logic                 last_vertex
);

    logic                 hold_valid_reg;
    logic                 hold_valid_next;
    vfqvb_pkg::item_t     hold_reg;
    logic [1:0]           slot_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [31:0]          vertex_reg;
    logic [23:0]          light_reg;
    logic [1:0]           out_slot_reg;
    logic                 last_reg;

    logic                 out_take;
    logic                 fire;
    logic                 item_take;
    vfqvb_pkg::corner_t   corner;
    vfqvb_pkg::offset_t   offset;
    logic [5:0]           vx;
    logic [5:0]           vy;
    logic [5:0]           vz;
    logic [3:0]           sun_n;
    logic [3:0]           occ_n;
    logic [31:0]          vertex_next;
    logic [23:0]          light_next;

    assign out_take   = !out_valid_reg || out_ready;
    assign fire       = hold_valid_reg && out_take;
    assign item_ready = !hold_valid_reg || (fire && slot_reg == 2'd3);
    assign item_take  = item_valid && item_ready;

    always_comb
    begin
        if (hold_reg.flip)
        begin
            corner = vfqvb_pkg::flipped_corner(slot_reg);
        end
        else
        begin
            corner = slot_reg;
        end
        offset = vfqvb_pkg::CORNER_OFFSET[hold_reg.face][corner];
        vx     = {1'b0, hold_reg.bx} + {5'b0, offset[2]};
        vy     = {1'b0, hold_reg.by} + {5'b0, offset[1]};
        vz     = {1'b0, hold_reg.bz} + {5'b0, offset[0]};
        sun_n  = hold_reg.sun[{corner, 2'b00} +: 4];
        occ_n  = hold_reg.occ[{corner, 2'b00} +: 4];
        vertex_next = {hold_reg.tex, corner, vz, vy, vx};
        light_next  = {occ_n, sun_n, 16'b0};
    end

    always_comb
    begin
        if (item_take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (fire && slot_reg == 2'd3)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_reg       <= 2'd0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (item_take)
            begin
                slot_reg <= 2'd0;
            end
            else if (fire)
            begin
                slot_reg <= slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            hold_reg <= item;
        end
        if (fire)
        begin
            vertex_reg   <= vertex_next;
            light_reg    <= light_next;
            out_slot_reg <= slot_reg;
            last_reg     <= (slot_reg == 2'd3);
        end
    end

    assign out_valid   = out_valid_reg;
    assign vertex_word = vertex_reg;
    assign light_word  = light_reg;
    assign slot        = out_slot_reg;
    assign last_vertex = last_reg;

endmodule

// ===== rtl/voxel_face_quad_vertex_builder_top.sv =====
// A face passes the stage 1, stage 2 and emitter hold registers before its first
// vertex is registered at the output. The single result channel moves one vertex
// beat per cycle unless out_ready stalls it; faces enter until stages 1-2 fill.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// Voxel face quad vertex builder
// Clamps the block position, sums corner light, picks the quad seam and
// emits four packed vertices per face.
// ----------------------------------------------------------------------------
module voxel_face_quad_vertex_builder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  block_i,
    input  logic [4:0]  block_j,
    input  logic [4:0]  block_k,
    input  logic [2:0]  face_dir,
    input  logic [11:0] texture_id,
    input  logic [15:0] sun_levels,
    input  logic [15:0] occlusion_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] vertex_word,
    output logic [23:0] light_word,
    output logic [1:0]  slot,
    output logic        last_vertex
);

    // Stage 1: clamped coordinates and per-corner light totals.
    logic               s1_valid_reg;
    vfqvb_pkg::item_t   s1_item_reg;
    logic [4:0]         s1_total_reg [0:3];
    logic               s1_ready;

    // Stage 2: seam decision.
    logic               s2_valid_reg;
    vfqvb_pkg::item_t   s2_item_reg;
    logic               s2_ready;

    logic               emit_ready;
    vfqvb_pkg::item_t   s1_item_next;
    vfqvb_pkg::item_t   s2_item_next;
    logic [4:0]         total_next [0:3];
    logic [4:0]         diff21;
    logic [4:0]         diff30;

    function automatic logic [4:0] clamp_coord(input logic [4:0] c);
        logic [4:0] r;
        if ({1'b0, c} > vfqvb_pkg::EDGE_MAX)
        begin
            r = vfqvb_pkg::EDGE_MAX[4:0];
        end
        else
        begin
            r = c;
        end
        return r;
    endfunction

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || emit_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        s1_item_next.bx   = clamp_coord(block_i);
        s1_item_next.by   = clamp_coord(block_j);
        s1_item_next.bz   = clamp_coord(block_k);
        s1_item_next.face = face_dir;
        s1_item_next.tex  = texture_id;
        s1_item_next.sun  = sun_levels;
        s1_item_next.occ  = occlusion_levels;
        s1_item_next.flip = 1'b0;
        for (int n = 0; n < 4; n++)
        begin
            total_next[n] = {1'b0, sun_levels[4*n +: 4]}
                          + {1'b0, occlusion_levels[4*n +: 4]};
        end
    end

    always_comb
    begin
        if (s1_total_reg[2] > s1_total_reg[1])
        begin
            diff21 = s1_total_reg[2] - s1_total_reg[1];
        end
        else
        begin
            diff21 = s1_total_reg[1] - s1_total_reg[2];
        end
        if (s1_total_reg[3] > s1_total_reg[0])
        begin
            diff30 = s1_total_reg[3] - s1_total_reg[0];
        end
        else
        begin
            diff30 = s1_total_reg[0] - s1_total_reg[3];
        end
        s2_item_next      = s1_item_reg;
        s2_item_next.flip = (diff21 > diff30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_item_reg <= s1_item_next;
            for (int n = 0; n < 4; n++)
            begin
                s1_total_reg[n] <= total_next[n];
            end
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    vfqvb_vertex_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s2_valid_reg),
        .item_ready  (emit_ready),
        .item        (s2_item_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .vertex_word (vertex_word),
        .light_word  (light_word),
        .slot        (slot),
        .last_vertex (last_vertex)
    );

endmodule
